>>> hdl/convex_polyhedron_point_test_core_defines.svh
// Assertion macros for the convex polyhedron point test block
`ifndef CONVEX_POLYHEDRON_POINT_TEST_CORE_DEFINES_SVH
`define CONVEX_POLYHEDRON_POINT_TEST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPT_ASSERT_SAME(lbl, ante, cons, msg)
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/cpt_pkg.sv
// Shared constants and types for the convex polyhedron point test
`timescale 1ns / 1ps

package cpt_pkg;

  localparam int MAX_FACES = 64;
  localparam int CNT_W     = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

  localparam int FIDX_W = 6;
  localparam int FCNT_W = 7;
  localparam int PT_W   = 20;
  localparam int NRM_W  = 16;
  localparam int QRY_W  = 12;
  localparam int FRAC_W = 8;
  localparam int DIFF_W = PT_W + 1;
  localparam int PROD_W = DIFF_W + NRM_W;
  localparam int SUM_W  = PROD_W + 2;

  // depth of the dot-product pipeline, from a face at the ring head to its hit flag
  localparam int DOT_LAT = 3;
  localparam int DRN_W   = 2;

  typedef struct packed {
    logic signed [PT_W-1:0]  pt_x;
    logic signed [PT_W-1:0]  pt_y;
    logic signed [PT_W-1:0]  pt_z;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } face_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUT
  } st_t;

endpackage

>>> hdl/cpt_cell.sv
// One ring cell: holds a single face entry, loaded directly or shifted from its neighbor
`timescale 1ns / 1ps

module cpt_cell (
  input  logic          clk,
  input  logic          load,
  input  logic          shift,
  input  cpt_pkg::face_t load_face,
  input  cpt_pkg::face_t shift_face,
  output cpt_pkg::face_t face
);
  import cpt_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      face <= load_face;
    end else if (shift) begin
      face <= shift_face;
    end
  end

endmodule

>>> hdl/cpt_dot.sv
// Pipelined dot product of (face point - query) with the face normal; flags a negative sum
`timescale 1ns / 1ps

module cpt_dot (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        act,
  input  cpt_pkg::face_t              face,
  input  logic signed [cpt_pkg::QRY_W-1:0] qx,
  input  logic signed [cpt_pkg::QRY_W-1:0] qy,
  input  logic signed [cpt_pkg::QRY_W-1:0] qz,
  output logic                        hit
);
  import cpt_pkg::*;

  logic                      s1_vld;
  logic signed [DIFF_W-1:0]  dx, dy, dz;
  logic signed [NRM_W-1:0]   nx, ny, nz;
  logic                      s2_vld;
  logic signed [PROD_W-1:0]  mx, my, mz;
  logic signed [SUM_W-1:0]   sum;

  // query scaled to Q12.8, both sides sign extended to the difference width
  always_ff @(posedge clk) begin
    dx <= {face.pt_x[PT_W-1], face.pt_x} - {qx[QRY_W-1], qx, {FRAC_W{1'b0}}};
    dy <= {face.pt_y[PT_W-1], face.pt_y} - {qy[QRY_W-1], qy, {FRAC_W{1'b0}}};
    dz <= {face.pt_z[PT_W-1], face.pt_z} - {qz[QRY_W-1], qz, {FRAC_W{1'b0}}};
    nx <= face.nrm_x;
    ny <= face.nrm_y;
    nz <= face.nrm_z;
  end

  always_ff @(posedge clk) begin
    mx <= PROD_W'(dx) * PROD_W'(nx);
    my <= PROD_W'(dy) * PROD_W'(ny);
    mz <= PROD_W'(dz) * PROD_W'(nz);
  end

  assign sum = SUM_W'(mx) + SUM_W'(my) + SUM_W'(mz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      s1_vld <= act;
      s2_vld <= s1_vld;
      hit    <= s2_vld && sum[SUM_W-1];
    end
  end

endmodule

>>> hdl/convex_polyhedron_point_test_core.sv
// Top level: face ring, dot-product unit, query sequencer and output register
// A load beat writes one ring cell. A query rotates the whole face ring once through the
// dot-product unit, drains the pipeline and posts once the output slot is free. Input is
// stalled outside the idle state, so only one query is in flight at a time.
// Synchronous active-high rst clears face_count, the sequencer and the output valid;
// face entries are not cleared and hold garbage until loaded.
`timescale 1ns / 1ps
`include "convex_polyhedron_point_test_core_defines.svh"

module convex_polyhedron_point_test_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cpt_pkg::FCNT_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [cpt_pkg::FIDX_W-1:0]        face_index,
  input  logic signed [cpt_pkg::PT_W-1:0]   point_x,
  input  logic signed [cpt_pkg::PT_W-1:0]   point_y,
  input  logic signed [cpt_pkg::PT_W-1:0]   point_z,
  input  logic signed [cpt_pkg::NRM_W-1:0]  normal_x,
  input  logic signed [cpt_pkg::NRM_W-1:0]  normal_y,
  input  logic signed [cpt_pkg::NRM_W-1:0]  normal_z,
  input  logic signed [cpt_pkg::QRY_W-1:0]  query_x,
  input  logic signed [cpt_pkg::QRY_W-1:0]  query_y,
  input  logic signed [cpt_pkg::QRY_W-1:0]  query_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              inside_res
);
  import cpt_pkg::*;

  st_t                     state, state_next;
  logic [FCNT_W-1:0]       face_count;
  logic [CNT_W-1:0]        cnt;
  logic [DRN_W-1:0]        drn;
  logic signed [QRY_W-1:0] qx, qy, qz;
  logic                    verdict;
  logic                    hit;

  logic                    in_beat;
  logic                    load_beat;
  logic                    query_beat;
  logic                    rotate;
  logic                    run_last;
  logic                    drn_last;
  logic                    slot_free;
  logic                    post;
  logic                    act;

  face_t                   new_face;
  face_t                   ring [MAX_FACES];

  assign in_beat    = in_valid && !in_stall;
  assign load_beat  = in_beat && !kind;
  assign query_beat = in_beat && kind;
  assign run_last   = (cnt == CNT_W'(MAX_FACES - 1));
  assign drn_last   = (drn == DRN_W'(DOT_LAT - 1));
  assign slot_free  = !out_valid || !out_stall;
  // faces past face_count ride the ring but are not checked
  assign act        = rotate && (32'(cnt) < 32'(face_count));

  assign new_face = '{pt_x: point_x, pt_y: point_y, pt_z: point_z,
                      nrm_x: normal_x, nrm_y: normal_y, nrm_z: normal_z};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (query_beat) state_next = ST_RUN;
      ST_RUN:   if (run_last)   state_next = ST_DRAIN;
      ST_DRAIN: if (drn_last)   state_next = ST_PUT;
      ST_PUT:   if (slot_free)  state_next = ST_IDLE;
      default:                  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = 1'b1;
    rotate   = 1'b0;
    post     = 1'b0;
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN:   rotate   = 1'b1;
      ST_DRAIN: ;
      ST_PUT:   post     = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      face_count <= '0;
      cnt        <= '0;
      drn        <= '0;
      verdict    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        face_count <= cfg_wr_data;
      end
      if (query_beat) begin
        cnt     <= '0;
        drn     <= '0;
        verdict <= 1'b1;
      end else begin
        if (rotate) begin
          cnt <= cnt + 1'b1;
        end
        if (state == ST_DRAIN) begin
          drn <= drn + 1'b1;
        end
        if (hit) begin
          verdict <= 1'b0;
        end
      end
      if (post) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_beat) begin
      qx <= query_x;
      qy <= query_y;
      qz <= query_z;
    end
    if (post) begin
      inside_res <= verdict;
    end
  end

  // ring of face cells; one full turn per query brings every entry home
  for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
    cpt_cell u_cell (
      .clk        (clk),
      .load       (load_beat && (32'(face_index) == i)),
      .shift      (rotate),
      .load_face  (new_face),
      .shift_face (ring[(i + 1) % MAX_FACES]),
      .face       (ring[i])
    );
  end

  cpt_dot u_dot (
    .clk  (clk),
    .rst  (rst),
    .act  (act),
    .face (ring[0]),
    .qx   (qx),
    .qy   (qy),
    .qz   (qz),
    .hit  (hit)
  );

  `CPT_ASSERT_NEXT(a_query_starts, query_beat, (state == ST_RUN) && (cnt == '0), "query did not start a ring turn")
  `CPT_ASSERT_NEXT(a_turn_ends, (state == ST_RUN) && run_last, state == ST_DRAIN, "ring turn did not end after all cells")
  `CPT_ASSERT_SAME(a_hit_in_query, hit, (state == ST_RUN) || (state == ST_DRAIN), "dot hit outside of a query")
  `CPT_ASSERT_NEXT(a_outside_sticks, (state == ST_RUN) && !verdict, !verdict, "outside verdict lost during a query")
  `CPT_ASSERT_SAME(a_post_from_put, $rose(out_valid), $past(state == ST_PUT), "result posted outside of the post state")

endmodule

>>> sim/tb.sv
// Testbench for the convex polyhedron point test core: directed table, then random solids
`timescale 1ns / 1ps

module tb;
  import cpt_pkg::*;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int LOAD_SETTLE  = 4;   // a load beat is registered into its ring cell
  localparam int DRAIN_CYCLES = 80;  // margin for the last query result to post
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AT      = 150;
  localparam int ROUNDS       = 10;
  localparam int ROUND_ITEMS  = 70;
  localparam logic [FCNT_W-1:0] ROUND_COUNT [7] = '{7'd127, 7'd64, 7'd1, 7'd63, 7'd0, 7'd65,
                                                   7'd32};

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_COUNT
  } row_act_t;

  typedef struct packed {
    logic                    kind;
    logic [FIDX_W-1:0]       idx;
    face_t                   fc;
    logic signed [QRY_W-1:0] qx;
    logic signed [QRY_W-1:0] qy;
    logic signed [QRY_W-1:0] qz;
  } beat_t;

  typedef struct {
    row_act_t          act;
    beat_t             b;
    logic [FCNT_W-1:0] cnt;
    logic              has_exp;
    logic              exp_inside;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [FCNT_W-1:0]       cfg_wr_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    kind;
  logic [FIDX_W-1:0]       face_index;
  logic signed [PT_W-1:0]  point_x, point_y, point_z;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
  logic signed [QRY_W-1:0] query_x, query_y, query_z;
  logic                    out_valid;
  logic                    out_stall;
  logic                    inside_res;

  // shadow copy of the face table and the face count
  face_t             face_tbl [MAX_FACES];
  logic [FCNT_W-1:0] face_limit;
  logic              inside_pending [$];
  row_t              dir_rows [$];
  int                err_count = 0;
  int                results_seen = 0;
  bit                hold_done = 1'b0;

  convex_polyhedron_point_test_core uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .face_index (face_index),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .query_x    (query_x),
    .query_y    (query_y),
    .query_z    (query_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // exact half-space test over the active faces
  function automatic logic predict_inside(input logic signed [QRY_W-1:0] qx, qy, qz);
    int     n;
    longint acc;
    n = (face_limit > MAX_FACES) ? MAX_FACES : int'(face_limit);
    for (int i = 0; i < n; i++) begin
      acc = (longint'($signed(face_tbl[i].pt_x)) - longint'(qx) * 256)
              * longint'($signed(face_tbl[i].nrm_x))
          + (longint'($signed(face_tbl[i].pt_y)) - longint'(qy) * 256)
              * longint'($signed(face_tbl[i].nrm_y))
          + (longint'($signed(face_tbl[i].pt_z)) - longint'(qz) * 256)
              * longint'($signed(face_tbl[i].nrm_z));
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.kind      = 1'($urandom());
    b.idx       = FIDX_W'($urandom());
    b.fc.pt_x   = PT_W'($urandom());
    b.fc.pt_y   = PT_W'($urandom());
    b.fc.pt_z   = PT_W'($urandom());
    b.fc.nrm_x  = NRM_W'($urandom());
    b.fc.nrm_y  = NRM_W'($urandom());
    b.fc.nrm_z  = NRM_W'($urandom());
    b.qx        = QRY_W'($urandom());
    b.qy        = QRY_W'($urandom());
    b.qz        = QRY_W'($urandom());
    return b;
  endfunction

  // face whose half-space keeps the center point inside
  function automatic beat_t solid_face(input int cx, cy, cz, sp);
    beat_t  b;
    int     px, py, pz, nx, ny, nz;
    longint dot;
    b = noise_beat();
    b.kind = KIND_LOAD;
    px = cx * 256 + int'($urandom_range(0, 2 * sp * 256)) - sp * 256;
    py = cy * 256 + int'($urandom_range(0, 2 * sp * 256)) - sp * 256;
    pz = cz * 256 + int'($urandom_range(0, 2 * sp * 256)) - sp * 256;
    nx = int'($urandom_range(0, 32768)) - 16384;
    ny = int'($urandom_range(0, 32768)) - 16384;
    nz = int'($urandom_range(0, 32768)) - 16384;
    dot = longint'(px - cx * 256) * nx + longint'(py - cy * 256) * ny
        + longint'(pz - cz * 256) * nz;
    if (dot < 0) begin
      nx = -nx;
      ny = -ny;
      nz = -nz;
    end
    b.fc.pt_x  = PT_W'(px);
    b.fc.pt_y  = PT_W'(py);
    b.fc.pt_z  = PT_W'(pz);
    b.fc.nrm_x = NRM_W'(nx);
    b.fc.nrm_y = NRM_W'(ny);
    b.fc.nrm_z = NRM_W'(nz);
    return b;
  endfunction

  function automatic logic signed [QRY_W-1:0] clamp_q(input int v);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return QRY_W'(v);
  endfunction

  function automatic beat_t near_query(input int cx, cy, cz, jit);
    beat_t b;
    b = noise_beat();
    b.kind = KIND_QUERY;
    b.qx = clamp_q(cx + int'($urandom_range(0, 2 * jit)) - jit);
    b.qy = clamp_q(cy + int'($urandom_range(0, 2 * jit)) - jit);
    b.qz = clamp_q(cz + int'($urandom_range(0, 2 * jit)) - jit);
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  task automatic send_beat(input beat_t b, input int gap, input logic has_exp,
                           input logic exp_inside);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= b.kind;
    face_index <= b.idx;
    point_x    <= b.fc.pt_x;
    point_y    <= b.fc.pt_y;
    point_z    <= b.fc.pt_z;
    normal_x   <= b.fc.nrm_x;
    normal_y   <= b.fc.nrm_y;
    normal_z   <= b.fc.nrm_z;
    query_x    <= b.qx;
    query_y    <= b.qy;
    query_z    <= b.qz;
    do @(posedge clk); while (in_stall);
    if (b.kind == KIND_LOAD) face_tbl[b.idx] = b.fc;
    else inside_pending = {inside_pending,
                           (has_exp ? exp_inside : predict_inside(b.qx, b.qy, b.qz))};
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (inside_pending.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input logic [FCNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    face_limit = v;
  endtask

  task automatic add_load(input int idx, px, py, pz, nx, ny, nz);
    row_t r;
    r.act        = ROW_LOAD;
    r.b          = noise_beat();
    r.b.kind     = KIND_LOAD;
    r.b.idx      = FIDX_W'(idx);
    r.b.fc.pt_x  = PT_W'(px);
    r.b.fc.pt_y  = PT_W'(py);
    r.b.fc.pt_z  = PT_W'(pz);
    r.b.fc.nrm_x = NRM_W'(nx);
    r.b.fc.nrm_y = NRM_W'(ny);
    r.b.fc.nrm_z = NRM_W'(nz);
    r.cnt        = '0;
    r.has_exp    = 1'b0;
    r.exp_inside = 1'b0;
    dir_rows = {dir_rows, r};
  endtask

  task automatic add_query(input int qx, qy, qz, input logic has_exp, exp_inside);
    row_t r;
    r.act        = ROW_QUERY;
    r.b          = noise_beat();
    r.b.kind     = KIND_QUERY;
    r.b.qx       = QRY_W'(qx);
    r.b.qy       = QRY_W'(qy);
    r.b.qz       = QRY_W'(qz);
    r.cnt        = '0;
    r.has_exp    = has_exp;
    r.exp_inside = exp_inside;
    dir_rows = {dir_rows, r};
  endtask

  task automatic add_count(input int v);
    row_t r;
    r.act        = ROW_COUNT;
    r.b          = '0;
    r.cnt        = FCNT_W'(v);
    r.has_exp    = 1'b0;
    r.exp_inside = 1'b0;
    dir_rows = {dir_rows, r};
  endtask

  // result checker
  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (inside_pending.size() == 0) begin
        report_mismatch($sformatf("inside_res=%0b with no query pending", inside_res));
      end else begin
        want = inside_pending.pop_front();
        if (inside_res !== want)
          report_mismatch($sformatf("inside_res=%0b, expected %0b", inside_res, want));
      end
    end
  end

  // output side stall pattern, with one long hold-off
  initial begin
    int   left, calm_left, r;
    logic v;
    left = 0;
    calm_left = 0;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      v = 1'b0;
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        left = LONG_HOLD;
      end
      if (left > 0) begin
        left--;
        v = 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
      end else begin
        r = $urandom_range(0, 999);
        if (r < 5) begin
          calm_left = $urandom_range(100, 300);
        end else if (r < 300) begin
          left = $urandom_range(0, 2);
          v = 1'b1;
        end else if (r < 320) begin
          left = $urandom_range(8, 50);
          v = 1'b1;
        end
      end
      out_stall <= v;
    end
  end

  initial begin
    beat_t             b;
    logic [FCNT_W-1:0] cnt;
    int                cx, cy, cz, spread, jit, start, sel;
    bit                calm;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    kind        = KIND_LOAD;
    face_index  = '0;
    point_x     = '0;
    point_y     = '0;
    point_z     = '0;
    normal_x    = '0;
    normal_y    = '0;
    normal_z    = '0;
    query_x     = '0;
    query_y     = '0;
    query_z     = '0;
    face_limit  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no faces after reset: everything is inside
    add_query(-2048, -2048, -2048, 1'b1, 1'b1);
    add_query(2047, 2047, 2047, 1'b1, 1'b1);
    add_load(0, 0, 0, 0, 16384, 0, 0);
    add_count(1);
    add_query(0, 2047, -2048, 1'b1, 1'b1);     // on the plane
    add_query(1, 0, 0, 1'b1, 1'b0);
    add_query(-2048, 0, 0, 1'b1, 1'b1);
    add_load(1, -524288, -524288, -524288, -16384, -16384, -16384);
    add_load(0, 524287, 524287, 524287, 16384, 16384, 16384);
    add_count(2);
    add_query(-2048, -2048, -2048, 1'b1, 1'b1);
    add_query(2047, 2047, 2047, 1'b1, 1'b1);
    add_load(1, 0, 0, 0, 0, 0, -16384);
    add_query(5, 5, -1, 1'b1, 1'b0);           // fails on the second face only
    add_query(5, 5, 0, 1'b1, 1'b1);
    add_count(1);
    add_query(5, 5, -1, 1'b1, 1'b1);           // second face not checked
    add_count(2);
    add_load(1, -524288, 524287, 3, -32768, 32767, -1);
    add_query(100, -100, 7, 1'b0, 1'b0);
    add_query(-2048, 2047, -2048, 1'b0, 1'b0);
    add_count(0);
    add_query(1, 1, 1, 1'b1, 1'b1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].act == ROW_COUNT) begin
        go_idle();
        write_count(dir_rows[i].cnt);
      end else begin
        send_beat(dir_rows[i].b, pick_gap(), dir_rows[i].has_exp, dir_rows[i].exp_inside);
      end
    end

    // each round: new count, a fresh convex solid in all entries, then mostly near queries
    for (int r = 0; r < ROUNDS; r++) begin
      go_idle();
      cnt = (r < 7) ? ROUND_COUNT[r] : FCNT_W'($urandom_range(0, 127));
      write_count(cnt);
      calm = (r % 3 == 1);
      cx = int'($urandom_range(0, 2800)) - 1400;
      cy = int'($urandom_range(0, 2800)) - 1400;
      cz = int'($urandom_range(0, 2800)) - 1400;
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 400);
      start = $urandom_range(0, MAX_FACES - 1);
      for (int i = 0; i < MAX_FACES; i++) begin
        b = solid_face(cx, cy, cz, spread);
        b.idx = FIDX_W'((i + start) % MAX_FACES);
        send_beat(b, calm ? 0 : pick_gap(), 1'b0, 1'b0);
      end
      for (int i = 0; i < ROUND_ITEMS; i++) begin
        if (r == 4 && i == ROUND_ITEMS / 2) go_idle();
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          b = noise_beat();
          b.kind = KIND_LOAD;
        end else if (sel < 18) begin
          b = noise_beat();
          b.kind = KIND_QUERY;
        end else if (sel < 24) begin
          b = solid_face(cx, cy, cz, spread);
          b.idx = FIDX_W'($urandom_range(0, MAX_FACES - 1));
        end else begin
          case ($urandom_range(0, 3))
            0:       jit = $urandom_range(0, 2);
            1:       jit = spread / 4;
            2:       jit = spread;
            default: jit = 3 * spread;
          endcase
          b = near_query(cx, cy, cz, jit);
        end
        send_beat(b, calm ? 0 : pick_gap(), 1'b0, 1'b0);
      end
    end

    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (inside_pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", inside_pending.size()));
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cpt_pkg.sv
hdl/cpt_cell.sv
hdl/cpt_dot.sv
hdl/convex_polyhedron_point_test_core.sv
sim/tb.sv
